>>> rtl/smbus_pec_frame_build_check_assert.svh
// Assertion macros for the SMBus PEC frame builder and checker.
`ifndef SMBUS_PEC_FRAME_BUILD_CHECK_ASSERT_SVH
`define SMBUS_PEC_FRAME_BUILD_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define SPFBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define SPFBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPFBC_ASSERT(lbl, prop, msg)
`define SPFBC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/spfbc_pkg.sv
// Shared types, codes and the PEC byte function for the SMBus PEC frame block.
package spfbc_pkg;

  typedef logic [8:0] flags_t;
  typedef logic [2:0] status_t;
  typedef logic [2:0] req_t;

  // Request types
  localparam req_t REQ_SEND_BYTE  = 3'd0;
  localparam req_t REQ_WRITE_BYTE = 3'd1;
  localparam req_t REQ_WRITE_WORD = 3'd2;
  localparam req_t REQ_READ_BYTE  = 3'd3;
  localparam req_t REQ_READ_WORD  = 3'd4;

  // Bus outcome codes
  localparam logic [2:0] OC_OK         = 3'd0;
  localparam logic [2:0] OC_NACK       = 3'd1;
  localparam logic [2:0] OC_BUSY_TMO   = 3'd4;
  localparam logic [2:0] OC_START_FAIL = 3'd5;
  localparam logic [2:0] OC_DONE_TMO   = 3'd6;

  // Status codes
  localparam status_t ST_OK   = 3'd0;
  localparam status_t ST_NACK = 3'd1;
  localparam status_t ST_BUS  = 3'd2;
  localparam status_t ST_TMO  = 3'd3;
  localparam status_t ST_PEC  = 3'd4;

  // Fault flag bit positions
  localparam int FLB_WRITE = 0;
  localparam int FLB_READ  = 1;
  localparam int FLB_ACK   = 2;
  localparam int FLB_NACK  = 3;
  localparam int FLB_BUS   = 4;
  localparam int FLB_TMO   = 5;
  localparam int FLB_START = 6;
  localparam int FLB_PEC   = 7;
  localparam int FLB_PARAM = 8;

  localparam flags_t FL_WRITE = flags_t'(1) << FLB_WRITE;
  localparam flags_t FL_READ  = flags_t'(1) << FLB_READ;
  localparam flags_t FL_ACK   = flags_t'(1) << FLB_ACK;
  localparam flags_t FL_NACK  = flags_t'(1) << FLB_NACK;
  localparam flags_t FL_BUS   = flags_t'(1) << FLB_BUS;
  localparam flags_t FL_TMO   = flags_t'(1) << FLB_TMO;
  localparam flags_t FL_START = flags_t'(1) << FLB_START;
  localparam flags_t FL_PEC   = flags_t'(1) << FLB_PEC;
  localparam flags_t FL_PARAM = flags_t'(1) << FLB_PARAM;

  // Transmit lengths
  localparam logic [2:0] TX_LEN_CMD  = 3'd1;
  localparam logic [2:0] TX_LEN_SEND = 3'd2;
  localparam logic [2:0] TX_LEN_BYTE = 3'd3;
  localparam logic [2:0] TX_LEN_WORD = 3'd4;

  localparam logic [7:0] PEC_POLY = 8'h07;

  // One incoming transaction
  typedef struct packed {
    req_t       req;
    logic [6:0] addr;
    logic [7:0] cmd;
    logic [15:0] wdata;
    logic [2:0] outcome;
    logic [7:0] rlo;
    logic [7:0] rhi;
    logic [7:0] rpec;
    logic       dest;
  } in_item_t;

  // After the first stage: PEC over write address and command
  typedef struct packed {
    req_t       req;
    logic [6:0] addr;
    logic [7:0] cmd;
    logic [7:0] dlo;
    logic [7:0] dhi;
    logic [7:0] rlo;
    logic [7:0] rhi;
    logic [7:0] rpec;
    logic       dest;
    logic [7:0] crc_ac;
    status_t    oc_st;
    flags_t     oc_flags;
  } front_t;

  // After the second stage: PEC one data byte further on each path
  typedef struct packed {
    req_t       req;
    logic [7:0] cmd;
    logic [7:0] dlo;
    logic [7:0] dhi;
    logic [7:0] rlo;
    logic [7:0] rhi;
    logic [7:0] rpec;
    logic       dest;
    logic [7:0] crc_ac;
    logic [7:0] crc_w1;
    logic [7:0] crc_r1;
    status_t    oc_st;
    flags_t     oc_flags;
  } mid_t;

  // Final result
  typedef struct packed {
    logic [31:0] frame;
    logic [2:0]  len;
    status_t     status;
    flags_t      flags;
    logic [15:0] rdata;
    logic [7:0]  pc;
    logic        pm;
  } result_t;

  // CRC-8 (poly 0x07) advanced over one byte
  function automatic logic [7:0] pec_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ PEC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/spfbc_front.sv
// First stage: PEC over write address and command, bus outcome decode.
module spfbc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  output logic                stall_o,
  input  spfbc_pkg::in_item_t item_i,
  output logic                vld_o,
  input  logic                stall_i,
  output spfbc_pkg::front_t   data_o
);
  import spfbc_pkg::*;

  logic    vld_r, vld_nxt, load;
  front_t  data_r, data_nxt;
  status_t oc_st;
  flags_t  oc_flags;

  // Outcome to status and flags; unused code behaves as other error
  always_comb begin
    case (item_i.outcome)
      OC_OK: begin
        oc_st = ST_OK;   oc_flags = FL_ACK;
      end
      OC_NACK: begin
        oc_st = ST_NACK; oc_flags = FL_NACK;
      end
      OC_BUSY_TMO: begin
        oc_st = ST_TMO;  oc_flags = FL_START | FL_TMO;
      end
      OC_START_FAIL: begin
        oc_st = ST_BUS;  oc_flags = FL_START;
      end
      OC_DONE_TMO: begin
        oc_st = ST_TMO;  oc_flags = FL_TMO;
      end
      default: begin
        oc_st = ST_BUS;  oc_flags = FL_BUS;
      end
    endcase
  end

  // Stage payload
  always_comb begin
    data_nxt.req      = item_i.req;
    data_nxt.addr     = item_i.addr;
    data_nxt.cmd      = item_i.cmd;
    data_nxt.dlo      = item_i.wdata[7:0];
    data_nxt.dhi      = item_i.wdata[15:8];
    data_nxt.rlo      = item_i.rlo;
    data_nxt.rhi      = item_i.rhi;
    data_nxt.rpec     = item_i.rpec;
    data_nxt.dest     = item_i.dest;
    data_nxt.crc_ac   = pec_byte(pec_byte(8'h00, {item_i.addr, 1'b0}), item_i.cmd);
    data_nxt.oc_st    = oc_st;
    data_nxt.oc_flags = oc_flags;
  end

  // Stage handshake
  assign load    = !vld_r || !stall_i;
  assign stall_o = !load;
  assign vld_nxt = load ? vld_i : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

>>> rtl/spfbc_mid.sv
// Second stage: PEC through the first data byte of the write and read paths.
module spfbc_mid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  output logic              stall_o,
  input  spfbc_pkg::front_t data_i,
  output logic              vld_o,
  input  logic              stall_i,
  output spfbc_pkg::mid_t   data_o
);
  import spfbc_pkg::*;

  logic vld_r, vld_nxt, load;
  mid_t data_r, data_nxt;

  // Write path adds the low data byte; read path adds read address and first byte
  always_comb begin
    data_nxt.req      = data_i.req;
    data_nxt.cmd      = data_i.cmd;
    data_nxt.dlo      = data_i.dlo;
    data_nxt.dhi      = data_i.dhi;
    data_nxt.rlo      = data_i.rlo;
    data_nxt.rhi      = data_i.rhi;
    data_nxt.rpec     = data_i.rpec;
    data_nxt.dest     = data_i.dest;
    data_nxt.crc_ac   = data_i.crc_ac;
    data_nxt.crc_w1   = pec_byte(data_i.crc_ac, data_i.dlo);
    data_nxt.crc_r1   = pec_byte(pec_byte(data_i.crc_ac, {data_i.addr, 1'b1}), data_i.rlo);
    data_nxt.oc_st    = data_i.oc_st;
    data_nxt.oc_flags = data_i.oc_flags;
  end

  // Stage handshake
  assign load    = !vld_r || !stall_i;
  assign stall_o = !load;
  assign vld_nxt = load ? vld_i : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

>>> rtl/spfbc_back.sv
// Last stage: final PEC byte, PEC compare, frame and status assembly.
module spfbc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  output logic               stall_o,
  input  spfbc_pkg::mid_t    data_i,
  output logic               vld_o,
  input  logic               stall_i,
  output spfbc_pkg::result_t res_o
);
  import spfbc_pkg::*;

  logic       vld_r, vld_nxt, load;
  result_t    res_r, res_nxt;
  logic [7:0] crc_w2, crc_r2, crc_rd;

  assign crc_w2 = pec_byte(data_i.crc_w1, data_i.dhi);
  assign crc_r2 = pec_byte(data_i.crc_r1, data_i.rhi);
  assign crc_rd = (data_i.req == REQ_READ_WORD) ? crc_r2 : data_i.crc_r1;

  // Result assembly per request type
  always_comb begin
    res_nxt.frame  = {24'd0, data_i.cmd};
    res_nxt.len    = TX_LEN_CMD;
    res_nxt.status = ST_BUS;
    res_nxt.flags  = FL_PARAM;
    res_nxt.rdata  = 16'd0;
    res_nxt.pc     = 8'd0;
    res_nxt.pm     = 1'b0;
    case (data_i.req)
      REQ_SEND_BYTE: begin
        res_nxt.frame  = {16'd0, data_i.crc_ac, data_i.cmd};
        res_nxt.len    = TX_LEN_SEND;
        res_nxt.status = data_i.oc_st;
        res_nxt.flags  = FL_WRITE | data_i.oc_flags;
        res_nxt.pc     = data_i.crc_ac;
      end
      REQ_WRITE_BYTE: begin
        res_nxt.frame  = {8'd0, data_i.crc_w1, data_i.dlo, data_i.cmd};
        res_nxt.len    = TX_LEN_BYTE;
        res_nxt.status = data_i.oc_st;
        res_nxt.flags  = FL_WRITE | data_i.oc_flags;
        res_nxt.pc     = data_i.crc_w1;
      end
      REQ_WRITE_WORD: begin
        res_nxt.frame  = {crc_w2, data_i.dhi, data_i.dlo, data_i.cmd};
        res_nxt.len    = TX_LEN_WORD;
        res_nxt.status = data_i.oc_st;
        res_nxt.flags  = FL_WRITE | data_i.oc_flags;
        res_nxt.pc     = crc_w2;
      end
      REQ_READ_BYTE, REQ_READ_WORD: begin
        if (!data_i.dest) begin
          res_nxt.flags = FL_READ | FL_PARAM;
        end else begin
          res_nxt.flags  = FL_READ | data_i.oc_flags;
          res_nxt.status = data_i.oc_st;
          if (data_i.oc_st == ST_OK) begin
            res_nxt.pc = crc_rd;
            if (crc_rd == data_i.rpec) begin
              res_nxt.pm    = 1'b1;
              res_nxt.rdata = (data_i.req == REQ_READ_WORD) ?
                              {data_i.rhi, data_i.rlo} : {8'd0, data_i.rlo};
            end else begin
              res_nxt.flags  = FL_READ | data_i.oc_flags | FL_PEC;
              res_nxt.status = ST_PEC;
            end
          end
        end
      end
      default: begin
        res_nxt.flags = FL_PARAM;
      end
    endcase
  end

  // Output register handshake
  assign load    = !vld_r || !stall_i;
  assign stall_o = !load;
  assign vld_nxt = load ? vld_i : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && vld_i) begin
      res_r <= res_nxt;
    end
  end

  assign vld_o = vld_r;
  assign res_o = res_r;

endmodule

>>> rtl/smbus_pec_frame_build_check.sv
// Top level of the SMBus/PMBus PEC frame builder and read checker.
//
// One PMBus transaction enters on the in_ channel per transfer (valid/stall);
// one result leaves on the out_ channel per transfer. Writes get their
// transmit frame with the CRC-8 PEC appended; reads get their received PEC
// checked and their data assembled, with status and fault flags.
// Three register stages: PEC over address and command, PEC over the first
// data byte, then the last byte, compare and assembly into the output
// register. An accepted transfer passes through the front, mid and output
// registers in turn. Throughput is one transaction per cycle while out_stall
// is low, set by the stage chain; each stage holds its valid bit and takes a
// new item whenever it is empty or its content moves on.
// When the receiver stalls, the output register holds its result and the
// stall works back stage by stage; in_stall rises only once all three
// stages are full. Nothing is lost or repeated.
// Synchronous reset empties all stages; out_valid is low after reset.
module smbus_pec_frame_build_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [6:0]  in_target_addr,
  input  logic [7:0]  in_command_code,
  input  logic [15:0] in_write_data,
  input  logic [2:0]  in_bus_outcome,
  input  logic [7:0]  in_rx_data_low,
  input  logic [7:0]  in_rx_data_high,
  input  logic [7:0]  in_rx_pec,
  input  logic        in_dest_valid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_tx_frame,
  output logic [2:0]  out_tx_len,
  output logic [2:0]  out_status,
  output logic [8:0]  out_fault_mask,
  output logic [15:0] out_read_data,
  output logic [7:0]  out_pec_crc,
  output logic        out_pec_match
);
  import spfbc_pkg::*;

  `include "smbus_pec_frame_build_check_assert.svh"

  in_item_t item;
  front_t   front_data;
  mid_t     mid_data;
  result_t  res;
  logic     front_vld, front_stall;
  logic     mid_vld, mid_stall;
  logic     ok_read, rw_both;

  // Gather the input fields
  assign item.req     = in_req_type;
  assign item.addr    = in_target_addr;
  assign item.cmd     = in_command_code;
  assign item.wdata   = in_write_data;
  assign item.outcome = in_bus_outcome;
  assign item.rlo     = in_rx_data_low;
  assign item.rhi     = in_rx_data_high;
  assign item.rpec    = in_rx_pec;
  assign item.dest    = in_dest_valid;

  // Stage chain
  spfbc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (in_valid),
    .stall_o (in_stall),
    .item_i  (item),
    .vld_o   (front_vld),
    .stall_i (front_stall),
    .data_o  (front_data)
  );

  spfbc_mid u_mid (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (front_vld),
    .stall_o (front_stall),
    .data_i  (front_data),
    .vld_o   (mid_vld),
    .stall_i (mid_stall),
    .data_o  (mid_data)
  );

  spfbc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (mid_vld),
    .stall_o (mid_stall),
    .data_i  (mid_data),
    .vld_o   (out_valid),
    .stall_i (out_stall),
    .res_o   (res)
  );

  // Result fields
  assign out_tx_frame   = res.frame;
  assign out_tx_len     = res.len;
  assign out_status     = res.status;
  assign out_fault_mask = res.flags;
  assign out_read_data  = res.rdata;
  assign out_pec_crc    = res.pc;
  assign out_pec_match  = res.pm;

  // Terms for the checks
  assign ok_read = (out_status == ST_OK) && out_fault_mask[FLB_READ];
  assign rw_both = out_fault_mask[FLB_WRITE] && out_fault_mask[FLB_READ];

  // Checks
  `SPFBC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "output valid after reset")
  `SPFBC_ASSERT(a_no_stall_when_empty, !out_valid |-> !in_stall, "input stalled with empty output")
  `SPFBC_ASSERT(a_match_is_ok_read, out_valid && out_pec_match |-> ok_read, "stray PEC match")
  `SPFBC_ASSERT(a_rw_exclusive, out_valid |-> !rw_both, "write and read flags both set")

endmodule

>>> tb/smbus_pec_frame_checker.sv
`timescale 1ns / 100ps
// Result predictor and scoreboard for the SMBus PEC frame builder and read checker.

package smbus_pec_model_pkg;
  import spfbc_pkg::*;

  // Bus outcome codes the block package leaves unnamed
  localparam logic [2:0] OC_BUS_ERR   = 3'd2;
  localparam logic [2:0] OC_OTHER_ERR = 3'd3;
  localparam logic [2:0] OC_SPARE     = 3'd7;

  // Request codes past the defined ones
  localparam req_t REQ_SPARE_LO = 3'd5;
  localparam req_t REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    status_t st;
    flags_t  fl;
  } bus_effect_t;

  // Serial CRC-8, MSB first, one data bit per step
  function automatic logic [7:0] crc8_advance(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0} ^ (fb ? PEC_POLY : 8'h00);
    end
    return c;
  endfunction

  // Status and fault flags for what the bus reported
  function automatic bus_effect_t bus_effect(input logic [2:0] oc);
    bus_effect_t e;
    case (oc)
      OC_OK: begin
        e.st = ST_OK;
        e.fl = FL_ACK;
      end
      OC_NACK: begin
        e.st = ST_NACK;
        e.fl = FL_NACK;
      end
      OC_BUSY_TMO: begin
        e.st = ST_TMO;
        e.fl = FL_START | FL_TMO;
      end
      OC_START_FAIL: begin
        e.st = ST_BUS;
        e.fl = FL_START;
      end
      OC_DONE_TMO: begin
        e.st = ST_TMO;
        e.fl = FL_TMO;
      end
      default: begin
        // bus error, other error and the spare code all land here
        e.st = ST_BUS;
        e.fl = FL_BUS;
      end
    endcase
    return e;
  endfunction

  // Full result of one transaction
  function automatic result_t frame_outcome(input in_item_t it);
    result_t     r;
    bus_effect_t e;
    logic [7:0]  aw;
    logic [7:0]  ar;
    logic [7:0]  crc;
    aw = {it.addr, 1'b0};
    ar = {it.addr, 1'b1};
    e  = bus_effect(it.outcome);
    r        = '0;
    r.frame  = {24'd0, it.cmd};
    r.len    = TX_LEN_CMD;
    r.status = ST_BUS;
    case (it.req)
      REQ_SEND_BYTE, REQ_WRITE_BYTE, REQ_WRITE_WORD: begin
        crc = crc8_advance(crc8_advance(8'h00, aw), it.cmd);
        if (it.req == REQ_SEND_BYTE) begin
          r.frame = {16'd0, crc, it.cmd};
          r.len   = TX_LEN_SEND;
        end else if (it.req == REQ_WRITE_BYTE) begin
          crc     = crc8_advance(crc, it.wdata[7:0]);
          r.frame = {8'd0, crc, it.wdata[7:0], it.cmd};
          r.len   = TX_LEN_BYTE;
        end else begin
          crc     = crc8_advance(crc8_advance(crc, it.wdata[7:0]), it.wdata[15:8]);
          r.frame = {crc, it.wdata[15:8], it.wdata[7:0], it.cmd};
          r.len   = TX_LEN_WORD;
        end
        r.pc     = crc;
        r.status = e.st;
        r.flags  = FL_WRITE | e.fl;
      end
      REQ_READ_BYTE, REQ_READ_WORD: begin
        r.flags = FL_READ;
        if (!it.dest) begin
          // no destination: outcome ignored
          r.flags = r.flags | FL_PARAM;
        end else begin
          r.status = e.st;
          r.flags  = r.flags | e.fl;
          if (e.st == ST_OK) begin
            crc = crc8_advance(crc8_advance(crc8_advance(8'h00, aw), it.cmd), ar);
            crc = crc8_advance(crc, it.rlo);
            if (it.req == REQ_READ_WORD) crc = crc8_advance(crc, it.rhi);
            r.pc = crc;
            if (crc == it.rpec) begin
              r.pm    = 1'b1;
              r.rdata = (it.req == REQ_READ_WORD) ? {it.rhi, it.rlo} : {8'd0, it.rlo};
            end else begin
              r.flags  = r.flags | FL_PEC;
              r.status = ST_PEC;
            end
          end
        end
      end
      default: begin
        r.flags = FL_PARAM;
      end
    endcase
    return r;
  endfunction

endpackage

module smbus_pec_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [6:0]  in_target_addr,
  input  logic [7:0]  in_command_code,
  input  logic [15:0] in_write_data,
  input  logic [2:0]  in_bus_outcome,
  input  logic [7:0]  in_rx_data_low,
  input  logic [7:0]  in_rx_data_high,
  input  logic [7:0]  in_rx_pec,
  input  logic        in_dest_valid,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_tx_frame,
  input  logic [2:0]  out_tx_len,
  input  logic [2:0]  out_status,
  input  logic [8:0]  out_fault_mask,
  input  logic [15:0] out_read_data,
  input  logic [7:0]  out_pec_crc,
  input  logic        out_pec_match,
  output int unsigned results_outstanding,
  output int unsigned results_checked,
  output int unsigned result_errors
);
  import spfbc_pkg::*;
  import smbus_pec_model_pkg::*;

  result_t awaited_results[$];

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      result_errors++;
    end
  endtask

  // Compare results first, then log the new transfer: latency keeps them apart
  always @(posedge clk) begin
    in_item_t seen;
    result_t  want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing pending: tx_frame %0h", out_tx_frame);
          result_errors++;
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          check_field("tx_frame", want.frame, out_tx_frame);
          check_field("tx_len", 32'(want.len), 32'(out_tx_len));
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("fault_mask", 32'(want.flags), 32'(out_fault_mask));
          check_field("read_data", 32'(want.rdata), 32'(out_read_data));
          check_field("pec_crc", 32'(want.pc), 32'(out_pec_crc));
          check_field("pec_match", 32'(want.pm), 32'(out_pec_match));
        end
      end
      if (in_valid && !in_stall) begin
        seen.req     = in_req_type;
        seen.addr    = in_target_addr;
        seen.cmd     = in_command_code;
        seen.wdata   = in_write_data;
        seen.outcome = in_bus_outcome;
        seen.rlo     = in_rx_data_low;
        seen.rhi     = in_rx_data_high;
        seen.rpec    = in_rx_pec;
        seen.dest    = in_dest_valid;
        awaited_results.push_back(frame_outcome(seen));
      end
    end
    results_outstanding <= awaited_results.size();
  end

endmodule

>>> tb/tb_smbus_pec_frame_build_check.sv
`timescale 1ns / 100ps
// Top of the SMBus PEC frame block testbench: clock, reset, stimulus and verdict.

module tb_smbus_pec_frame_build_check;
  import spfbc_pkg::*;
  import smbus_pec_model_pkg::*;

  localparam int PHASE_ITEMS    = 625;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [6:0]  in_target_addr = '0;
  logic [7:0]  in_command_code = '0;
  logic [15:0] in_write_data = '0;
  logic [2:0]  in_bus_outcome = '0;
  logic [7:0]  in_rx_data_low = '0;
  logic [7:0]  in_rx_data_high = '0;
  logic [7:0]  in_rx_pec = '0;
  logic        in_dest_valid = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_tx_frame;
  logic [2:0]  out_tx_len;
  logic [2:0]  out_status;
  logic [8:0]  out_fault_mask;
  logic [15:0] out_read_data;
  logic [7:0]  out_pec_crc;
  logic        out_pec_match;

  int unsigned results_outstanding;
  int unsigned results_checked;
  int unsigned result_errors;

  int          tx_idle_pct = 26;
  int          rx_idle_pct = 66;
  logic        hold_req = 1'b0;
  int unsigned n_sent = 0;
  int unsigned idle_cycles = 0;

  smbus_pec_frame_build_check u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_target_addr  (in_target_addr),
    .in_command_code (in_command_code),
    .in_write_data   (in_write_data),
    .in_bus_outcome  (in_bus_outcome),
    .in_rx_data_low  (in_rx_data_low),
    .in_rx_data_high (in_rx_data_high),
    .in_rx_pec       (in_rx_pec),
    .in_dest_valid   (in_dest_valid),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tx_frame    (out_tx_frame),
    .out_tx_len      (out_tx_len),
    .out_status      (out_status),
    .out_fault_mask  (out_fault_mask),
    .out_read_data   (out_read_data),
    .out_pec_crc     (out_pec_crc),
    .out_pec_match   (out_pec_match)
  );

  smbus_pec_frame_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_target_addr      (in_target_addr),
    .in_command_code     (in_command_code),
    .in_write_data       (in_write_data),
    .in_bus_outcome      (in_bus_outcome),
    .in_rx_data_low      (in_rx_data_low),
    .in_rx_data_high     (in_rx_data_high),
    .in_rx_pec           (in_rx_pec),
    .in_dest_valid       (in_dest_valid),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tx_frame        (out_tx_frame),
    .out_tx_len          (out_tx_len),
    .out_status          (out_status),
    .out_fault_mask      (out_fault_mask),
    .out_read_data       (out_read_data),
    .out_pec_crc         (out_pec_crc),
    .out_pec_match       (out_pec_match),
    .results_outstanding (results_outstanding),
    .results_checked     (results_checked),
    .result_errors       (result_errors)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic in_item_t make_item(input req_t req, input logic [6:0] addr,
                                         input logic [7:0] cmd, input logic [15:0] wd,
                                         input logic [2:0] oc, input logic [7:0] rlo,
                                         input logic [7:0] rhi, input logic [7:0] rpec,
                                         input logic dest);
    in_item_t it;
    it.req     = req;
    it.addr    = addr;
    it.cmd     = cmd;
    it.wdata   = wd;
    it.outcome = oc;
    it.rlo     = rlo;
    it.rhi     = rhi;
    it.rpec    = rpec;
    it.dest    = dest;
    return it;
  endfunction

  // Give a read the PEC a clean bus would have delivered
  function automatic in_item_t seal_read_pec(input in_item_t it);
    in_item_t probe;
    result_t  clean;
    probe         = it;
    probe.outcome = OC_OK;
    probe.dest    = 1'b1;
    clean         = frame_outcome(probe);
    it.rpec       = clean.pc;
    return it;
  endfunction

  // Mostly well-formed transactions, reads largely with a correct PEC
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.addr  = 7'($urandom);
    it.cmd   = 8'($urandom);
    it.wdata = 16'($urandom);
    it.rlo   = 8'($urandom);
    it.rhi   = 8'($urandom);
    it.rpec  = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 6) it.req = req_t'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
    else if (pick < 46) it.req = req_t'($urandom_range(REQ_WRITE_WORD, REQ_SEND_BYTE));
    else it.req = req_t'($urandom_range(REQ_READ_WORD, REQ_READ_BYTE));
    it.outcome = ($urandom_range(99) < 55) ? OC_OK : 3'($urandom_range(7, 1));
    it.dest    = ($urandom_range(99) < 90);
    if ((it.req == REQ_READ_BYTE || it.req == REQ_READ_WORD) && $urandom_range(99) < 80)
      it = seal_read_pec(it);
    return it;
  endfunction

  // Offer one transaction, with random idle cycles first, and wait for the transfer
  task automatic send_transfer(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= it.req;
    in_target_addr  <= it.addr;
    in_command_code <= it.cmd;
    in_write_data   <= it.wdata;
    in_bus_outcome  <= it.outcome;
    in_rx_data_low  <= it.rlo;
    in_rx_data_high <= it.rhi;
    in_rx_pec       <= it.rpec;
    in_dest_valid   <= it.dest;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // Sender goes quiet until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  // Receiver: random stall, or a long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    in_item_t it;
    int       k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every request type and every bus outcome
    send_transfer(make_item(REQ_SEND_BYTE, 7'h00, 8'h00, 16'h0000, OC_OK, 8'h00, 8'h00,
                            8'h00, 1'b0));
    send_transfer(make_item(REQ_SEND_BYTE, 7'h7f, 8'hff, 16'hffff, OC_OK, 8'hff, 8'hff,
                            8'hff, 1'b1));
    send_transfer(make_item(REQ_WRITE_BYTE, 7'h7f, 8'hff, 16'hffff, OC_OK, 8'h00, 8'h00,
                            8'h00, 1'b1));
    send_transfer(make_item(REQ_WRITE_BYTE, 7'h00, 8'h00, 16'h0000, OC_NACK, 8'hff, 8'hff,
                            8'hff, 1'b0));
    send_transfer(make_item(REQ_WRITE_WORD, 7'h7f, 8'hff, 16'hffff, OC_OK, 8'h12, 8'h34,
                            8'h56, 1'b1));
    send_transfer(make_item(REQ_WRITE_WORD, 7'h00, 8'h00, 16'h0000, OC_OK, 8'h00, 8'h00,
                            8'h00, 1'b0));
    send_transfer(make_item(REQ_WRITE_WORD, 7'h55, 8'ha5, 16'h5aa5, OC_BUS_ERR, 8'h00, 8'h00,
                            8'h00, 1'b1));
    send_transfer(make_item(REQ_SEND_BYTE, 7'h2a, 8'h33, 16'h0000, OC_OTHER_ERR, 8'h00,
                            8'h00, 8'h00, 1'b1));
    send_transfer(make_item(REQ_WRITE_BYTE, 7'h11, 8'h22, 16'hff33, OC_BUSY_TMO, 8'h00,
                            8'h00, 8'h00, 1'b1));
    send_transfer(make_item(REQ_WRITE_WORD, 7'h12, 8'h34, 16'h5678, OC_START_FAIL, 8'h00,
                            8'h00, 8'h00, 1'b1));
    send_transfer(make_item(REQ_SEND_BYTE, 7'h01, 8'h02, 16'h0000, OC_DONE_TMO, 8'h00,
                            8'h00, 8'h00, 1'b1));
    // spare outcome code behaves as other error
    send_transfer(make_item(REQ_WRITE_BYTE, 7'h03, 8'h04, 16'h0005, OC_SPARE, 8'h00, 8'h00,
                            8'h00, 1'b1));
    // reads with good PEC
    send_transfer(seal_read_pec(make_item(REQ_READ_BYTE, 7'h7f, 8'hff, 16'h0000, OC_OK,
                                          8'hff, 8'hff, 8'h00, 1'b1)));
    send_transfer(seal_read_pec(make_item(REQ_READ_WORD, 7'h00, 8'h00, 16'h0000, OC_OK,
                                          8'h00, 8'h00, 8'h00, 1'b1)));
    send_transfer(seal_read_pec(make_item(REQ_READ_WORD, 7'h7f, 8'hff, 16'hffff, OC_OK,
                                          8'hff, 8'hff, 8'h00, 1'b1)));
    send_transfer(seal_read_pec(make_item(REQ_READ_BYTE, 7'h2c, 8'h8b, 16'h0000, OC_OK,
                                          8'h5e, 8'hc3, 8'h00, 1'b1)));
    // reads with a corrupted PEC
    it = seal_read_pec(make_item(REQ_READ_WORD, 7'h40, 8'h79, 16'h0000, OC_OK, 8'h9a,
                                 8'h01, 8'h00, 1'b1));
    it.rpec = it.rpec ^ 8'h01;
    send_transfer(it);
    it = seal_read_pec(make_item(REQ_READ_BYTE, 7'h08, 8'h8c, 16'h0000, OC_OK, 8'h77,
                                 8'h00, 8'h00, 1'b1));
    it.rpec = it.rpec ^ 8'h80;
    send_transfer(it);
    // reads with no destination: outcome is ignored
    send_transfer(make_item(REQ_READ_BYTE, 7'h10, 8'h20, 16'h0000, OC_NACK, 8'h30, 8'h40,
                            8'h50, 1'b0));
    send_transfer(seal_read_pec(make_item(REQ_READ_WORD, 7'h5a, 8'h88, 16'h0000, OC_OK,
                                          8'h21, 8'h43, 8'h00, 1'b0)));
    // reads that failed on the bus
    send_transfer(seal_read_pec(make_item(REQ_READ_WORD, 7'h33, 8'h99, 16'h0000, OC_NACK,
                                          8'h11, 8'h22, 8'h00, 1'b1)));
    send_transfer(seal_read_pec(make_item(REQ_READ_BYTE, 7'h44, 8'h98, 16'h0000,
                                          OC_START_FAIL, 8'h11, 8'h22, 8'h00, 1'b1)));
    send_transfer(seal_read_pec(make_item(REQ_READ_WORD, 7'h45, 8'h97, 16'h0000,
                                          OC_DONE_TMO, 8'h11, 8'h22, 8'h00, 1'b1)));
    // unknown request types
    for (k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++)
      send_transfer(make_item(req_t'(k), 7'h7f, 8'hc7, 16'hbeef, OC_OK, 8'hff, 8'hff, 8'hff,
                              1'b1));
    drain_results();

    // Random, sender idling lightly and receiver heavily
    for (k = 0; k < PHASE_ITEMS; k++) send_transfer(random_item());
    drain_results();

    // Random, roles swapped
    tx_idle_pct = 66;
    rx_idle_pct = 26;
    for (k = 0; k < PHASE_ITEMS; k++) send_transfer(random_item());
    drain_results();

    // Random at full rate, with one long receiver hold while the sender keeps offering
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (k = 0; k < PHASE_ITEMS; k++) begin
      if (k == PHASE_ITEMS / 2) hold_req <= 1'b1;
      send_transfer(random_item());
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d transactions, %0d results checked: every request and outcome code,",
             n_sent, results_checked);
    $display("good and bad read PECs, three idling mixes and a %0d-cycle result hold.",
             HOLD_CYCLES);
    if (results_outstanding != 0)
      $error("%0d expected results never arrived", results_outstanding);
    if (result_errors == 0 && results_outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/spfbc_pkg.sv
rtl/spfbc_front.sv
rtl/spfbc_mid.sv
rtl/spfbc_back.sv
rtl/smbus_pec_frame_build_check.sv
tb/smbus_pec_frame_checker.sv
tb/tb_smbus_pec_frame_build_check.sv
